[rtl/txc_pkg.sv]
// Shared types and constants for the text console writer.
package txc_pkg;

   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [15:0] CELL_ATTR    = 16'h0F00;

   localparam logic [7:0]  COLUMNS_RESET = 8'd80;
   localparam logic [5:0]  ROWS_RESET    = 6'd25;

   localparam int          CSR_W       = 8;
   localparam int          CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_SCROLL_CLR,
      ST_FINISH
   } state_type;

endpackage

[rtl/txc_cell_ram.sv]
// Character cell buffer: one write port and one registered read port.
module txc_cell_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/text_console_writer.sv]
// Text console: cell buffer, cursor, newline, wrap and scroll, with cell read-back.
// One item at a time under a small sequencer sharing one multiplier.
// A read, or a character or newline write that does not scroll, passes from the
// idle step through its read or write step and the finish step, which loads the
// output register and returns to idle for the next item. A write that scrolls adds
// a pass that moves each cell of the kept rows up one row, with one buffer read and
// one buffer write per moved cell, and a pass with one write per cleared cell of the
// last row. A result that is still waiting in the output register holds the sequencer
// in its finish step. After reset a clearing pass zeroes all MAX_COLUMNS*MAX_ROWS
// cells (4096 by default) before the first item is taken; configuration writes are
// taken throughout. A finished result waits in an output register, and the next item
// may be taken meanwhile.
module text_console_writer #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: char_code[7:0], cell_index[19:8], zero [23:20]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,
   // req_tuser: action[0]
   input  logic                             req_tuser,
   // rsp_tdata: cell_value[15:0], cursor_column[22:16], cursor_row[27:23],
   //            did_scroll[28], zero [31:29]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,
   input  logic                             csr_we,
   input  logic [txc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [txc_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int BUF_CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W    = (BUF_CELLS > 1) ? $clog2(BUF_CELLS) : 1;
   localparam int PTR_W     = $clog2(BUF_CELLS + 1);
   localparam int CW        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ECW       = $clog2(MAX_COLUMNS + 1);
   localparam int ERW       = $clog2(MAX_ROWS + 1);

   txc_pkg::state_type state_ff, state_in;

   logic [7:0]        cols_ff;
   logic [5:0]        rows_ff;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [PTR_W-1:0]  keep_ff, keep_in;
   logic [PTR_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        code_ff, code_in;
   logic              inr_ff, inr_in;
   logic [15:0]       value_ff, value_in;
   logic              scroll_ff, scroll_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   logic [ECW-1:0]    ecols, ccol, ncol;
   logic [ERW-1:0]    erows, crow, nrow;
   logic [PTR_W-1:0]  mul_a, mul_b, mul_p;
   logic              req_xfer;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [15:0]       ram_wdata, ram_rdata;

   txc_cell_ram #(
      .DEPTH  (BUF_CELLS),
      .ADDR_W (ADDR_W),
      .DATA_W (16)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // geometry limits
   always_comb begin
      if (cols_ff == 8'd0) begin
         ecols = ECW'(1);
      end else if (int'(cols_ff) > MAX_COLUMNS) begin
         ecols = ECW'(MAX_COLUMNS);
      end else begin
         ecols = ECW'(cols_ff);
      end
      if (rows_ff == 6'd0) begin
         erows = ERW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         erows = ERW'(MAX_ROWS);
      end else begin
         erows = ERW'(rows_ff);
      end
      ccol = (ECW'(cur_col_ff) >= ecols) ? ecols - ECW'(1) : ECW'(cur_col_ff);
      crow = (ERW'(cur_row_ff) >= erows) ? erows - ERW'(1) : ERW'(cur_row_ff);
   end

   assign mul_p      = PTR_W'(mul_a * mul_b);
   assign req_tready = (state_ff == txc_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= txc_pkg::ST_CLEAR;
         ptr_ff       <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cols_ff      <= txc_pkg::COLUMNS_RESET;
         rows_ff      <= txc_pkg::ROWS_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               txc_pkg::CSR_COLUMNS: cols_ff <= csr_wdata;
               txc_pkg::CSR_ROWS:    rows_ff <= csr_wdata[5:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      keep_ff     <= keep_in;
      total_ff    <= total_in;
      addr_ff     <= addr_in;
      code_ff     <= code_in;
      inr_ff      <= inr_in;
      value_ff    <= value_in;
      scroll_ff   <= scroll_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      keep_in      = keep_ff;
      total_in     = total_ff;
      addr_in      = addr_ff;
      code_in      = code_ff;
      inr_in       = inr_ff;
      value_in     = value_ff;
      scroll_in    = scroll_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = PTR_W'(crow);
      mul_b        = PTR_W'(ecols);
      ncol         = ECW'(cur_col_ff);
      nrow         = ERW'(cur_row_ff);
      ram_we       = 1'b0;
      ram_waddr    = ADDR_W'(ptr_ff);
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = ADDR_W'(req_tdata[19:8]);

      unique case (state_ff)
         txc_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ptr_in = ptr_ff + PTR_W'(1);
            if (ptr_ff == PTR_W'(BUF_CELLS - 1)) begin
               state_in = txc_pkg::ST_IDLE;
            end
         end
         txc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               code_in   = req_tdata[7:0];
               value_in  = '0;
               scroll_in = 1'b0;
               if (req_tuser) begin
                  inr_in   = (int'(req_tdata[19:8]) < BUF_CELLS);
                  ram_re   = inr_in;
                  state_in = txc_pkg::ST_READ;
               end else begin
                  addr_in    = ADDR_W'(mul_p + PTR_W'(ccol));
                  cur_col_in = CW'(ccol);
                  cur_row_in = RW'(crow);
                  state_in   = txc_pkg::ST_WRITE;
               end
            end
         end
         txc_pkg::ST_READ: begin
            value_in = inr_ff ? ram_rdata : '0;
            state_in = txc_pkg::ST_FINISH;
         end
         txc_pkg::ST_WRITE: begin
            mul_a    = PTR_W'(erows - ERW'(1));
            mul_b    = PTR_W'(ecols);
            keep_in  = mul_p;
            total_in = mul_p + PTR_W'(ecols);
            if (code_ff == txc_pkg::NEWLINE_CODE) begin
               ncol = '0;
               nrow = ERW'(cur_row_ff) + ERW'(1);
            end else begin
               ram_we    = 1'b1;
               ram_waddr = addr_ff;
               ram_wdata = txc_pkg::CELL_ATTR | {8'd0, code_ff};
               ncol      = ECW'(cur_col_ff) + ECW'(1);
               if (ncol >= ecols) begin
                  ncol = '0;
                  nrow = ERW'(cur_row_ff) + ERW'(1);
               end
            end
            if (nrow >= erows) begin
               nrow      = erows - ERW'(1);
               scroll_in = 1'b1;
               ptr_in    = '0;
               state_in  = txc_pkg::ST_SCROLL_RD;
            end else begin
               state_in  = txc_pkg::ST_FINISH;
            end
            cur_col_in = CW'(ncol);
            cur_row_in = RW'(nrow);
         end
         txc_pkg::ST_SCROLL_RD: begin
            if (ptr_ff < keep_ff) begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(ptr_ff + PTR_W'(ecols));
               state_in  = txc_pkg::ST_SCROLL_WR;
            end else begin
               state_in  = txc_pkg::ST_SCROLL_CLR;
            end
         end
         txc_pkg::ST_SCROLL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_ff + PTR_W'(1);
            state_in  = txc_pkg::ST_SCROLL_RD;
         end
         txc_pkg::ST_SCROLL_CLR: begin
            if (ptr_ff < total_ff) begin
               ram_we = 1'b1;
               ptr_in = ptr_ff + PTR_W'(1);
            end else begin
               state_in = txc_pkg::ST_FINISH;
            end
         end
         txc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, scroll_ff, 5'(cur_row_ff), 7'(cur_col_ff), value_ff};
               state_in     = txc_pkg::ST_IDLE;
            end
         end
         default: state_in = txc_pkg::ST_IDLE;
      endcase
   end

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == txc_pkg::ST_CLEAR) |-> !req_tready)
      else $error("item taken during clearing pass");

   a_cursor_row_in_screen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == txc_pkg::ST_WRITE) |=> (ERW'(cur_row_ff) < erows))
      else $error("cursor row left the screen after a write");

   a_scroll_move_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == txc_pkg::ST_SCROLL_WR) |-> (ptr_ff < keep_ff))
      else $error("scroll moved a cell beyond the kept rows");

   a_scroll_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == txc_pkg::ST_SCROLL_CLR) |-> (ptr_ff <= total_ff))
      else $error("scroll clear ran past the screen");

endmodule
